[rtl/core/esc_throttle_pulse_decoder_macros.svh]
// ----------------------------------------------------------------------------
// ESC throttle pulse decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ESC_THROTTLE_PULSE_DECODER_MACROS_SVH
`define ESC_THROTTLE_PULSE_DECODER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ETPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ETPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/etpd_pkg.sv]
// ----------------------------------------------------------------------------
// etpd_pkg
// Types, register codes and constants of the ESC throttle pulse decoder.
// ----------------------------------------------------------------------------
package etpd_pkg;

  typedef enum logic [2:0] {
    PROTO_MULTISHOT  = 3'd0,
    PROTO_ONESHOT42  = 3'd1,
    PROTO_ONESHOT125 = 3'd2,
    PROTO_PPM        = 3'd3,
    PROTO_DSHOT      = 3'd4
  } protocol_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_BIDIR  = 2'd2
  } throttle_mode_t;

  typedef enum logic {
    ACTION_PULSE = 1'b0,
    ACTION_TICK  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_PROTOCOL_SELECT   = 3'd0,
    REG_CLOCK_FAST        = 3'd1,
    REG_THROTTLE_MODE     = 3'd2,
    REG_REVERSE_DEFAULT   = 3'd3,
    REG_CENTER_PULSE      = 3'd4,
    REG_MINIMUM_PULSE     = 3'd5,
    REG_FORWARD_GAIN_WORD = 3'd6,
    REG_REVERSE_GAIN_WORD = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  protocol_select;
    logic        clock_fast;
    logic [1:0]  throttle_mode;
    logic        reverse_default;
    logic [11:0] center_pulse;
    logic [11:0] minimum_pulse;
    logic [10:0] forward_gain_word;
    logic [10:0] reverse_gain_word;
  } cfg_t;

  typedef struct packed {
    logic       in_startup;
    logic       in_initial_run;
    logic       motor_running;
    logic [7:0] startup_floor;
    logic [7:0] stall_events;
  } motor_state_t;

  typedef struct packed {
    logic [15:0] value;
    logic        stop;
    logic        direction;
    logic        boosted;
  } map_result_t;

  // reset values of the configuration registers
  localparam logic [2:0]  RST_PROTOCOL_SELECT   = 3'd4;
  localparam logic        RST_CLOCK_FAST        = 1'b0;
  localparam logic [1:0]  RST_THROTTLE_MODE     = 2'd0;
  localparam logic        RST_REVERSE_DEFAULT   = 1'b0;
  localparam logic [11:0] RST_CENTER_PULSE      = 12'd1500;
  localparam logic [11:0] RST_MINIMUM_PULSE     = 12'd1000;
  localparam logic [10:0] RST_FORWARD_GAIN_WORD = 11'd128;
  localparam logic [10:0] RST_REVERSE_GAIN_WORD = 11'd128;

  localparam logic [7:0]  BAD_LIMIT       = 8'd50;
  localparam logic [3:0]  TIMEOUT_RELOAD  = 4'd10;
  localparam logic [15:0] PULSE_MIN       = 16'd900;
  localparam logic [15:0] PULSE_END       = 16'd2235;
  localparam logic [15:0] FULL_RANGE_BASE = 16'd1000;
  localparam logic [15:0] DEADBAND        = 16'd10;
  localparam logic [17:0] MULTI_OFS_FAST  = 18'h00600;
  localparam logic [17:0] MULTI_OFS_SLOW  = 18'h00300;
  // 0x56 / 2: one product serves oneshot125 and ppm
  localparam logic [21:0] RATE_MUL        = 22'h2b;
  localparam int          GAIN_FRAC       = 7;

endpackage

[rtl/core/esc_throttle_pulse_decoder.sv]
// ----------------------------------------------------------------------------
// esc_throttle_pulse_decoder
// RC pulse / timer tick decoder producing the stored throttle and status.
// ----------------------------------------------------------------------------
// Pipeline: a word accepted into the input register is decoded and captured
//   in the result register once it is free; m_axis_tvalid rises with it.
// Throughput: one word per cycle unless the output stalls; state (throttle,
//   counters) updates in the same cycle as the result, so the next word sees it.
// Reset: synchronous, clears the pipeline, the throttle and all counters and
//   loads the configuration registers with their defaults.
module esc_throttle_pulse_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_pulse[15:0], in_startup[16], in_initial_run[17], motor_running[18],
  // startup_floor[26:19], stall_events[34:27], zero[39:35]
  input  logic [39:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // throttle_out[15:0], scaled_pulse[31:16], out_of_range[32], stop_flag[33],
  // direction_flag[34], timeout_reload[35], throttle_written[36],
  // throttle_cleared[37], boost_applied[38], timeout_left[42:39],
  // zero_run[50:43], zero[55:51]
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "esc_throttle_pulse_decoder_macros.svh"

  etpd_pkg::cfg_t         cfg;
  etpd_pkg::motor_state_t s1_motor;
  etpd_pkg::map_result_t  mapped;

  logic        s1_valid;
  logic        s1_action;
  logic [15:0] s1_raw;
  logic        advance;
  logic        s_fire;

  logic [15:0] throttle_store, throttle_store_next;
  logic [3:0]  timeout_counter, timeout_counter_next;
  logic [7:0]  stop_counter, stop_counter_next;
  logic [7:0]  bad_pulse_counter, bad_pulse_counter_next;
  logic [7:0]  bad_inc;

  logic [15:0] scaled;
  logic        oor;
  logic [15:0] scaled_res;
  logic        oor_res, stop_res, dir_res, reload_res, written_res, cleared_res, boost_res;

  logic        out_valid;
  logic [15:0] out_throttle, out_scaled;
  logic        out_oor, out_stop, out_dir, out_reload, out_written, out_cleared, out_boost;
  logic [3:0]  out_timeout;
  logic [7:0]  out_zero_run;

  etpd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etpd_rescale u_rescale (
    .raw_pulse    (s1_raw),
    .cfg          (cfg),
    .scaled_pulse (scaled)
  );

  etpd_throttle_map u_map (
    .scaled_pulse (scaled),
    .cfg          (cfg),
    .motor        (s1_motor),
    .result       (mapped)
  );

  assign advance       = s1_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~s1_valid | advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_action               <= s_axis_tuser;
      s1_raw                  <= s_axis_tdata[15:0];
      s1_motor.in_startup     <= s_axis_tdata[16];
      s1_motor.in_initial_run <= s_axis_tdata[17];
      s1_motor.motor_running  <= s_axis_tdata[18];
      s1_motor.startup_floor  <= s_axis_tdata[26:19];
      s1_motor.stall_events   <= s_axis_tdata[34:27];
    end
  end

  assign oor     = (scaled < etpd_pkg::PULSE_MIN) || (scaled >= etpd_pkg::PULSE_END);
  assign bad_inc = (bad_pulse_counter == 8'hFF) ? 8'hFF : (bad_pulse_counter + 8'd1);

  // state update and result for the word in the input register
  always_comb begin
    throttle_store_next    = throttle_store;
    timeout_counter_next   = timeout_counter;
    stop_counter_next      = stop_counter;
    bad_pulse_counter_next = bad_pulse_counter;
    scaled_res  = 16'd0;
    oor_res     = 1'b0;
    stop_res    = 1'b0;
    dir_res     = 1'b0;
    reload_res  = 1'b0;
    written_res = 1'b0;
    cleared_res = 1'b0;
    boost_res   = 1'b0;
    if (s1_action == etpd_pkg::ACTION_TICK) begin
      if (timeout_counter != 4'd0) begin
        timeout_counter_next = timeout_counter - 4'd1;
      end
      if (throttle_store == 16'd0) begin
        stop_counter_next = (stop_counter == 8'hFF) ? 8'hFF : (stop_counter + 8'd1);
      end else begin
        stop_counter_next = 8'd0;
      end
    end else begin
      scaled_res           = scaled;
      dir_res              = cfg.reverse_default;
      reload_res           = 1'b1;
      timeout_counter_next = etpd_pkg::TIMEOUT_RELOAD;
      if (oor) begin
        oor_res                = 1'b1;
        bad_pulse_counter_next = bad_inc;
        if (bad_inc >= etpd_pkg::BAD_LIMIT) begin
          cleared_res         = 1'b1;
          written_res         = 1'b1;
          throttle_store_next = 16'd0;
        end
      end else begin
        stop_res            = mapped.stop;
        dir_res             = mapped.direction;
        boost_res           = mapped.boosted;
        written_res         = 1'b1;
        throttle_store_next = mapped.value;
        if (bad_pulse_counter != 8'd0) begin
          bad_pulse_counter_next = bad_pulse_counter - 8'd1;
        end
        if (mapped.value == 16'd0) begin
          stop_counter_next = (stop_counter == 8'hFF) ? 8'hFF : (stop_counter + 8'd1);
        end else begin
          stop_counter_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_store    <= 16'd0;
      timeout_counter   <= 4'd0;
      stop_counter      <= 8'd0;
      bad_pulse_counter <= 8'd0;
    end else if (advance) begin
      throttle_store    <= throttle_store_next;
      timeout_counter   <= timeout_counter_next;
      stop_counter      <= stop_counter_next;
      bad_pulse_counter <= bad_pulse_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_throttle <= throttle_store_next;
      out_scaled   <= scaled_res;
      out_oor      <= oor_res;
      out_stop     <= stop_res;
      out_dir      <= dir_res;
      out_reload   <= reload_res;
      out_written  <= written_res;
      out_cleared  <= cleared_res;
      out_boost    <= boost_res;
      out_timeout  <= timeout_counter_next;
      out_zero_run <= stop_counter_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_zero_run, out_timeout, out_boost, out_cleared,
                          out_written, out_reload, out_dir, out_stop, out_oor,
                          out_scaled, out_throttle};

  `ETPD_ASSERT_NOW(a_timeout_bound, 1'b1, timeout_counter <= etpd_pkg::TIMEOUT_RELOAD,
    "timeout counter above reload value")
  `ETPD_ASSERT_NEXT(a_pulse_reload,
    advance && (s1_action == etpd_pkg::ACTION_PULSE),
    timeout_counter == etpd_pkg::TIMEOUT_RELOAD, "pulse did not reload timeout")
  `ETPD_ASSERT_NOW(a_cleared_zero, out_valid && out_cleared,
    (out_throttle == 16'd0) && out_written && out_oor, "cleared result with throttle set")
  `ETPD_ASSERT_NOW(a_boost_valid, out_valid && out_boost,
    out_written && !out_oor && !out_cleared, "boost on a word that stored no mapped pulse")
  `ETPD_ASSERT_NEXT(a_stage_hold, s1_valid && !advance, s1_valid,
    "input register dropped a stalled word")

endmodule

[rtl/core/etpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// etpd_cfg_regs
// APB register file holding the decoder configuration.
// ----------------------------------------------------------------------------
module etpd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output etpd_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_select   <= etpd_pkg::RST_PROTOCOL_SELECT;
      cfg.clock_fast        <= etpd_pkg::RST_CLOCK_FAST;
      cfg.throttle_mode     <= etpd_pkg::RST_THROTTLE_MODE;
      cfg.reverse_default   <= etpd_pkg::RST_REVERSE_DEFAULT;
      cfg.center_pulse      <= etpd_pkg::RST_CENTER_PULSE;
      cfg.minimum_pulse     <= etpd_pkg::RST_MINIMUM_PULSE;
      cfg.forward_gain_word <= etpd_pkg::RST_FORWARD_GAIN_WORD;
      cfg.reverse_gain_word <= etpd_pkg::RST_REVERSE_GAIN_WORD;
    end else if (wr_en) begin
      unique case (reg_sel)
        etpd_pkg::REG_PROTOCOL_SELECT:   cfg.protocol_select   <= pwdata[2:0];
        etpd_pkg::REG_CLOCK_FAST:        cfg.clock_fast        <= pwdata[0];
        etpd_pkg::REG_THROTTLE_MODE:     cfg.throttle_mode     <= pwdata[1:0];
        etpd_pkg::REG_REVERSE_DEFAULT:   cfg.reverse_default   <= pwdata[0];
        etpd_pkg::REG_CENTER_PULSE:      cfg.center_pulse      <= pwdata[11:0];
        etpd_pkg::REG_MINIMUM_PULSE:     cfg.minimum_pulse     <= pwdata[11:0];
        etpd_pkg::REG_FORWARD_GAIN_WORD: cfg.forward_gain_word <= pwdata[10:0];
        etpd_pkg::REG_REVERSE_GAIN_WORD: cfg.reverse_gain_word <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      etpd_pkg::REG_PROTOCOL_SELECT:   prdata = {29'd0, cfg.protocol_select};
      etpd_pkg::REG_CLOCK_FAST:        prdata = {31'd0, cfg.clock_fast};
      etpd_pkg::REG_THROTTLE_MODE:     prdata = {30'd0, cfg.throttle_mode};
      etpd_pkg::REG_REVERSE_DEFAULT:   prdata = {31'd0, cfg.reverse_default};
      etpd_pkg::REG_CENTER_PULSE:      prdata = {20'd0, cfg.center_pulse};
      etpd_pkg::REG_MINIMUM_PULSE:     prdata = {20'd0, cfg.minimum_pulse};
      etpd_pkg::REG_FORWARD_GAIN_WORD: prdata = {21'd0, cfg.forward_gain_word};
      etpd_pkg::REG_REVERSE_GAIN_WORD: prdata = {21'd0, cfg.reverse_gain_word};
      default:                         prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/etpd_rescale.sv]
// ----------------------------------------------------------------------------
// etpd_rescale
// Protocol rescaling of a captured pulse width, saturated to 16 bits.
// ----------------------------------------------------------------------------
module etpd_rescale (
  input  logic [15:0]    raw_pulse,
  input  etpd_pkg::cfg_t cfg,
  output logic [15:0]    scaled_pulse
);

  logic [17:0] multi_sum;
  logic [16:0] os42_sum;
  logic [21:0] prod43;

  assign multi_sum = {1'b0, raw_pulse, 1'b0} + {6'd0, raw_pulse[15:4]}
                   + {7'd0, raw_pulse[15:5]}
                   + (cfg.clock_fast ? etpd_pkg::MULTI_OFS_FAST : etpd_pkg::MULTI_OFS_SLOW);
  assign os42_sum  = {1'b0, raw_pulse} + {8'd0, raw_pulse[15:7]};
  assign prod43    = {6'd0, raw_pulse} * etpd_pkg::RATE_MUL;

  always_comb begin
    unique case (cfg.protocol_select)
      etpd_pkg::PROTO_MULTISHOT:
        scaled_pulse = (|multi_sum[17:16]) ? 16'hFFFF : multi_sum[15:0];
      etpd_pkg::PROTO_ONESHOT42:
        scaled_pulse = os42_sum[16] ? 16'hFFFF : os42_sum[15:0];
      etpd_pkg::PROTO_ONESHOT125:
        scaled_pulse = {1'b0, prod43[21:7]};
      // ppm uses 86 >> 11, the same as 43 >> 10
      etpd_pkg::PROTO_PPM:
        scaled_pulse = {4'd0, prod43[21:10]};
      default:
        scaled_pulse = raw_pulse;
    endcase
  end

endmodule

[rtl/core/etpd_throttle_map.sv]
// ----------------------------------------------------------------------------
// etpd_throttle_map
// Mode mapping, packed gain, saturation and startup boost of a valid pulse.
// ----------------------------------------------------------------------------
module etpd_throttle_map (
  input  logic [15:0]            scaled_pulse,
  input  etpd_pkg::cfg_t         cfg,
  input  etpd_pkg::motor_state_t motor,
  output etpd_pkg::map_result_t  result
);

  logic [15:0] center16;
  logic [15:0] min16;
  logic        rev;
  logic [15:0] origin;
  logic [15:0] diff_bi;
  logic [15:0] base;
  logic [10:0] gain_word;
  logic [23:0] prod;
  logic [23:0] shifted;
  logic [15:0] gained;
  logic [12:0] boost;
  logic        boost_on;
  logic        below_min;
  logic        dir_sel;

  assign center16  = {4'd0, cfg.center_pulse};
  assign min16     = {4'd0, cfg.minimum_pulse};
  assign rev       = scaled_pulse < center16;
  assign origin    = rev ? min16 : center16;
  assign diff_bi   = (scaled_pulse > origin) ? (scaled_pulse - origin) : 16'd0;
  assign below_min = scaled_pulse < min16;

  always_comb begin
    gain_word = cfg.forward_gain_word;
    dir_sel   = cfg.reverse_default;
    unique case (cfg.throttle_mode)
      etpd_pkg::MODE_FULL: begin
        base = (scaled_pulse > etpd_pkg::FULL_RANGE_BASE)
             ? (scaled_pulse - etpd_pkg::FULL_RANGE_BASE) : 16'd0;
      end
      etpd_pkg::MODE_BIDIR: begin
        base = (diff_bi > etpd_pkg::DEADBAND) ? (diff_bi - etpd_pkg::DEADBAND) : 16'd0;
        dir_sel   = rev ^ cfg.reverse_default;
        gain_word = rev ? cfg.reverse_gain_word : cfg.forward_gain_word;
      end
      default: begin
        base = (scaled_pulse > min16) ? (scaled_pulse - min16) : 16'd0;
      end
    endcase
  end

  // gain over 128, then the packed left shift, saturate to 16 bits
  assign prod    = {8'd0, base} * {16'd0, gain_word[7:0]};
  assign shifted = {7'd0, prod[23:etpd_pkg::GAIN_FRAC]} << gain_word[10:8];
  assign gained  = (|shifted[23:16]) ? 16'hFFFF : shifted[15:0];

  assign boost = (cfg.clock_fast ? {4'd0, motor.startup_floor, 1'b0}
                                 : {5'd0, motor.startup_floor})
               + {1'b0, motor.stall_events, 4'd0};
  assign boost_on = (motor.in_startup | motor.in_initial_run) & ~motor.motor_running
                  & (gained != 16'd0);

  always_comb begin
    result.direction = dir_sel;
    result.stop = (gained == 16'd0) ||
                  ((cfg.throttle_mode != etpd_pkg::MODE_FULL) &&
                   (cfg.throttle_mode != etpd_pkg::MODE_BIDIR) && below_min);
    if (boost_on && (gained < {3'd0, boost})) begin
      result.value   = {3'd0, boost};
      result.boosted = 1'b1;
    end else begin
      result.value   = gained;
      result.boosted = 1'b0;
    end
  end

endmodule
